FILE: rtl/amge_pkg.sv
package amge_pkg;

    localparam int MAX_VERTICES_DEF = 16;

    // Widths of the fields on the ports
    localparam int CMD_W    = 3;
    localparam int VTX_W    = 5;
    localparam int STATUS_W = 2;
    localparam int DEG_W    = 4;
    localparam int ROW_W    = 16;
    localparam int VT_W     = 5;
    localparam int ET_W     = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_DEGREE = 3'd3,
        CMD_ROW    = 3'd4,
        CMD_APPEND = 3'd5,
        CMD_REMOVE = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

endpackage

FILE: rtl/amge_row_mem.sv
module amge_row_mem #(
    parameter int WIDTH = amge_pkg::MAX_VERTICES_DEF,
    parameter int DEPTH = amge_pkg::MAX_VERTICES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] rows_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rows_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= rows_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/adjacency_matrix_graph_engine_top.sv
// Channel | Handshake           | Word
// command | cmd_valid/cmd_stall | command, vertex_a, vertex_b, init_count
// result  | res_valid/res_stall | status, degree, neighbor_row, vertex_total, edge_total
//
// One command word is worked on at a time; the matrix lives in a single row memory with
// one write port and a registered read, so the cost is one row write per cycle.
// Append and rejected words go straight to the result, a query reads one row, an edge
// update writes rows a and b if it changes the edge; init and remove walk the rows.
// Reset clears counts, sequencer and output; no row is read before it is written.
// A finished result waits in the output register while the next word is taken in.
module adjacency_matrix_graph_engine_top #(
    parameter int MAX_VERTICES = amge_pkg::MAX_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [amge_pkg::CMD_W-1:0]    command,
    input  logic [amge_pkg::VTX_W-1:0]    vertex_a,
    input  logic [amge_pkg::VTX_W-1:0]    vertex_b,
    input  logic [amge_pkg::VTX_W-1:0]    init_count,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [amge_pkg::STATUS_W-1:0] status,
    output logic [amge_pkg::DEG_W-1:0]    degree,
    output logic [amge_pkg::ROW_W-1:0]    neighbor_row,
    output logic [amge_pkg::VT_W-1:0]     vertex_total,
    output logic [amge_pkg::ET_W-1:0]     edge_total
);

    import amge_pkg::*;

    localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int EW   = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);
    localparam int DW   = $clog2(MAX_VERTICES);
    localparam int CMPW = (CW > VTX_W) ? CW : VTX_W;
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_EDGE_A,
        S_EDGE_B,
        S_QUERY,
        S_DEL_DEG,
        S_DEL_SHIFT,
        S_DEL_FIN,
        S_RESULT
    } state_t;

    function automatic logic [DW-1:0] count_ones(input logic [MAX_VERTICES-1:0] v);
        logic [DW-1:0] c;
        c = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            c = c + DW'(v[i]);
        end
        return c;
    endfunction

    state_t                  state_reg;
    cmd_t                    op_reg;
    logic [AW-1:0]           ka_reg;
    logic [AW-1:0]           kb_reg;
    logic [AW-1:0]           idx_reg;
    logic [AW-1:0]           last_reg;
    logic [CW-1:0]           n_reg;
    logic [EW-1:0]           e_reg;
    status_t                 res_status_reg;
    logic [DW-1:0]           res_deg_reg;
    logic [MAX_VERTICES-1:0] res_row_reg;

    logic                    res_valid_reg;
    logic                    res_valid_next;
    logic [STATUS_W-1:0]     status_reg;
    logic [DEG_W-1:0]        degree_reg;
    logic [ROW_W-1:0]        neighbor_row_reg;
    logic [VT_W-1:0]         vertex_total_reg;
    logic [ET_W-1:0]         edge_total_reg;

    cmd_t                    cmd_e;
    logic                    cmd_accept;
    logic                    a_ok;
    logic                    b_ok;
    logic [AW-1:0]           ka_in;
    logic [AW-1:0]           kb_in;
    logic [AW-1:0]           last_in;
    state_t                  dec_state;
    status_t                 dec_status;
    logic                    out_free;

    logic                    mem_wr_en;
    logic [AW-1:0]           mem_wr_addr;
    logic [MAX_VERTICES-1:0] mem_wr_data;
    logic [AW-1:0]           mem_rd_addr;
    logic [MAX_VERTICES-1:0] rd_data;

    logic                    insert_op;
    logic                    edge_change;
    logic [AW-1:0]           set_pos;
    logic [MAX_VERTICES-1:0] edge_row;
    logic [MAX_VERTICES-1:0] keep_mask;
    logic [MAX_VERTICES-1:0] dropped_row;
    logic [AW-1:0]           shift_j;
    logic [AW-1:0]           shift_src;

    assign cmd_e      = cmd_t'(command);
    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign out_free   = !res_valid_reg || !res_stall;

    assign a_ok    = (vertex_a != '0) && (CMPW'(vertex_a) <= CMPW'(n_reg));
    assign b_ok    = (vertex_b != '0) && (CMPW'(vertex_b) <= CMPW'(n_reg));
    assign ka_in   = AW'(vertex_a - VTX_W'(1));
    assign kb_in   = AW'(vertex_b - VTX_W'(1));
    assign last_in = (cmd_e == CMD_INIT) ? AW'(init_count - VTX_W'(1))
                                         : AW'(n_reg - CW'(2));

    always_comb
    begin
        dec_state  = S_RESULT;
        dec_status = ST_OK;
        unique case (cmd_e)
            CMD_INIT:
            begin
                if (CMPW'(init_count) > CMPW'(MAX_VERTICES))
                begin
                    dec_status = ST_RANGE;
                end
                else if (init_count != '0)
                begin
                    dec_state = S_INIT;
                end
            end
            CMD_APPEND:
            begin
                if (n_reg >= CW'(MAX_VERTICES))
                begin
                    dec_status = ST_FULL;
                end
            end
            CMD_INSERT, CMD_DELETE:
            begin
                if (n_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (!a_ok || !b_ok || (vertex_a == vertex_b))
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_state = S_EDGE_A;
                end
            end
            CMD_DEGREE, CMD_ROW:
            begin
                if (n_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (!a_ok)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_state = S_QUERY;
                end
            end
            CMD_REMOVE:
            begin
                if (n_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (!a_ok)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_state = S_DEL_DEG;
                end
            end
            default:
            begin
                dec_status = ST_RANGE;
            end
        endcase
    end

    // Edge update: the first pass rewrites row a at bit b, the second row b at bit a.
    assign insert_op   = (op_reg == CMD_INSERT);
    assign edge_change = insert_op ? !rd_data[kb_reg] : rd_data[kb_reg];
    assign set_pos     = (state_reg == S_EDGE_A) ? kb_reg : ka_reg;

    always_comb
    begin
        edge_row          = rd_data;
        edge_row[set_pos] = insert_op;
    end

    // Removing column k: bits below k stay, bits above k move down by one.
    assign keep_mask   = (ROW_ONE << ka_reg) - ROW_ONE;
    assign dropped_row = (rd_data & keep_mask) | ((rd_data >> 1) & ~keep_mask);

    // Row j of the shrunk matrix comes from row j, or from row j + 1 from the deleted row on.
    // Reads always run ahead of the row being written, so no forwarding is needed.
    assign shift_j   = (state_reg == S_DEL_DEG) ? '0 : idx_reg + AW'(1);
    assign shift_src = (shift_j < ka_reg) ? shift_j : shift_j + AW'(1);

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg;
        mem_wr_data = '0;
        mem_rd_addr = ka_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_rd_addr = ka_in;
                if (cmd_accept && (cmd_e == CMD_APPEND) && (dec_status == ST_OK))
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = AW'(n_reg);
                    mem_wr_data = ROW_ONE << n_reg;
                end
            end
            S_INIT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = ROW_ONE << idx_reg;
            end
            S_EDGE_A:
            begin
                mem_rd_addr = kb_reg;
                mem_wr_en   = edge_change;
                mem_wr_addr = ka_reg;
                mem_wr_data = edge_row;
            end
            S_EDGE_B:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = kb_reg;
                mem_wr_data = edge_row;
            end
            S_DEL_DEG:
            begin
                mem_rd_addr = shift_src;
            end
            S_DEL_SHIFT:
            begin
                mem_rd_addr = shift_src;
                mem_wr_en   = 1'b1;
                mem_wr_data = dropped_row;
            end
            default:
            begin
            end
        endcase
    end

    // The output word stays valid while stalled and is refilled from the result state.
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if ((state_reg == S_RESULT) && out_free)
        begin
            res_valid_next = 1'b1;
        end
    end

    amge_row_mem #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_row_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= CMD_INIT;
            ka_reg           <= '0;
            kb_reg           <= '0;
            idx_reg          <= '0;
            last_reg         <= '0;
            n_reg            <= '0;
            e_reg            <= '0;
            res_status_reg   <= ST_OK;
            res_deg_reg      <= '0;
            res_row_reg      <= '0;
            res_valid_reg    <= 1'b0;
            status_reg       <= '0;
            degree_reg       <= '0;
            neighbor_row_reg <= '0;
            vertex_total_reg <= '0;
            edge_total_reg   <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_accept)
                    begin
                        state_reg      <= dec_state;
                        op_reg         <= cmd_e;
                        ka_reg         <= ka_in;
                        kb_reg         <= kb_in;
                        idx_reg        <= '0;
                        last_reg       <= last_in;
                        res_status_reg <= dec_status;
                        res_deg_reg    <= '0;
                        res_row_reg    <= '0;
                        if ((cmd_e == CMD_INIT) && (dec_status == ST_OK) && (init_count == '0))
                        begin
                            n_reg <= '0;
                            e_reg <= '0;
                        end
                        if ((cmd_e == CMD_APPEND) && (dec_status == ST_OK))
                        begin
                            n_reg <= n_reg + CW'(1);
                        end
                    end
                end
                S_INIT:
                begin
                    if (idx_reg == last_reg)
                    begin
                        n_reg     <= CW'(last_reg) + CW'(1);
                        e_reg     <= '0;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                S_EDGE_A:
                begin
                    state_reg <= edge_change ? S_EDGE_B : S_RESULT;
                end
                S_EDGE_B:
                begin
                    e_reg     <= insert_op ? e_reg + EW'(1) : e_reg - EW'(1);
                    state_reg <= S_RESULT;
                end
                S_QUERY:
                begin
                    if (op_reg == CMD_ROW)
                    begin
                        res_row_reg <= rd_data;
                    end
                    else
                    begin
                        res_deg_reg <= count_ones(rd_data & ~(ROW_ONE << ka_reg));
                    end
                    state_reg <= S_RESULT;
                end
                S_DEL_DEG:
                begin
                    res_deg_reg <= count_ones(rd_data & ~(ROW_ONE << ka_reg));
                    state_reg   <= (n_reg == CW'(1)) ? S_DEL_FIN : S_DEL_SHIFT;
                end
                S_DEL_SHIFT:
                begin
                    if (idx_reg == last_reg)
                    begin
                        state_reg <= S_DEL_FIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                S_DEL_FIN:
                begin
                    e_reg     <= (e_reg >= EW'(res_deg_reg)) ? e_reg - EW'(res_deg_reg) : '0;
                    n_reg     <= n_reg - CW'(1);
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        status_reg       <= res_status_reg;
                        degree_reg       <= DEG_W'(res_deg_reg);
                        neighbor_row_reg <= ROW_W'(res_row_reg);
                        vertex_total_reg <= VT_W'(n_reg);
                        edge_total_reg   <= ET_W'(e_reg);
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign degree       = degree_reg;
    assign neighbor_row = neighbor_row_reg;
    assign vertex_total = vertex_total_reg;
    assign edge_total   = edge_total_reg;

endmodule

FILE: rtl/amge_checker.sv
module amge_checker #(
    parameter int MAX_VERTICES = amge_pkg::MAX_VERTICES_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_stall,
    input logic [amge_pkg::STATUS_W-1:0] status,
    input logic [amge_pkg::DEG_W-1:0]    degree,
    input logic [amge_pkg::ROW_W-1:0]    neighbor_row,
    input logic [amge_pkg::VT_W-1:0]     vertex_total,
    input logic [amge_pkg::ET_W-1:0]     edge_total
);

    import amge_pkg::*;

    // A stalled result word holds still.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(status) && $stable(vertex_total)
            && $stable(edge_total) && $stable(degree) && $stable(neighbor_row))
        else $error("result word changed while stalled");

    // An empty graph has no edges, and a rejected command reports neither degree nor row.
    a_empty_counts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_EMPTY) |-> (vertex_total == '0) && (edge_total == '0))
        else $error("empty status with non-zero counts");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != ST_OK) |-> (degree == '0) && (neighbor_row == '0))
        else $error("rejected command carries degree or row");

    // A full graph holds exactly the maximum number of vertices.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_FULL) |-> (vertex_total == VT_W'(MAX_VERTICES)))
        else $error("full status with wrong vertex count");

    // Degree and row are never reported together.
    a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (degree == '0) || (neighbor_row == '0))
        else $error("degree and row both reported");

endmodule

bind adjacency_matrix_graph_engine_top amge_checker #(
    .MAX_VERTICES (MAX_VERTICES)
) u_amge_checker (.*);
